FILE: rtl/assert_macros.svh
// Assertion macros used by the top RTL file of the outlier window unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("dqow assertion failed");
`define DQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("dqow assertion failed");
`else
`define DQ_ASSERT(label, clk, rst_n, prop)
`define DQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: rtl/dqow_pkg.sv
`timescale 1ns / 1ps
package dqow_pkg;

    localparam int WINDOW_SIZE_DEF  = 8;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CRIT_W    = 10;
    localparam int TABLE_LEN = 28;
    localparam int MIN_SIZE  = 3;

    localparam logic [1:0] LEVEL_90 = 2'd0;
    localparam logic [1:0] LEVEL_95 = 2'd1;

    typedef enum logic [1:0] {
        VERDICT_NONE = 2'd0,
        VERDICT_LOW  = 2'd1,
        VERDICT_HIGH = 2'd2
    } t_verdict;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic gaps_en;
        logic mult_en;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic full_after;
        logic rd_last;
        logic out_free;
    } t_status;

    // Q0.10 critical values for window sizes 3 to 30.
    localparam logic [CRIT_W-1:0] CRIT90 [TABLE_LEN] = '{
        10'd964, 10'd783, 10'd657, 10'd573, 10'd519, 10'd479, 10'd447,
        10'd422, 10'd401, 10'd385, 10'd370, 10'd357, 10'd346, 10'd337,
        10'd328, 10'd321, 10'd313, 10'd307, 10'd302, 10'd297, 10'd292,
        10'd288, 10'd284, 10'd280, 10'd275, 10'd272, 10'd269, 10'd266
    };
    localparam logic [CRIT_W-1:0] CRIT95 [TABLE_LEN] = '{
        10'd993, 10'd849, 10'd727, 10'd640, 10'd582, 10'd539, 10'd505,
        10'd477, 10'd455, 10'd436, 10'd420, 10'd406, 10'd393, 10'd383,
        10'd374, 10'd365, 10'd357, 10'd350, 10'd345, 10'd339, 10'd334,
        10'd329, 10'd325, 10'd319, 10'd315, 10'd312, 10'd308, 10'd297
    };
    localparam logic [CRIT_W-1:0] CRIT99 [TABLE_LEN] = '{
        10'd1018, 10'd948, 10'd841, 10'd758, 10'd696, 10'd649, 10'd612,
        10'd582, 10'd555, 10'd535, 10'd515, 10'd500, 10'd486, 10'd474,
        10'd463, 10'd453, 10'd443, 10'd435, 10'd428, 10'd421, 10'd414,
        10'd409, 10'd402, 10'd397, 10'd393, 10'd389, 10'd385, 10'd381
    };

    function automatic int table_index(input int size);
        int idx;
        idx = size - MIN_SIZE;
        if (idx < 0) begin
            idx = 0;
        end
        if (idx > TABLE_LEN - 1) begin
            idx = TABLE_LEN - 1;
        end
        return idx;
    endfunction

    function automatic logic [CRIT_W-1:0] crit_value(input logic [1:0] level, input int idx);
        logic [CRIT_W-1:0] v;
        case (level)
            LEVEL_90: v = CRIT90[idx];
            LEVEL_95: v = CRIT95[idx];
            default:  v = CRIT99[idx];
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/dqow_ram.sv
`timescale 1ns / 1ps
module dqow_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dqow_ctrl.sv
`timescale 1ns / 1ps
module dqow_ctrl
    import dqow_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_GAPS  = 6'b001000,
        ST_MULT  = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_status.full_after ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_status.rd_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_GAPS;
            end
            ST_GAPS: begin
                o_cmd.gaps_en = 1'b1;
                n_state       = ST_MULT;
            end
            ST_MULT: begin
                o_cmd.mult_en = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

FILE: rtl/dqow_dp.sv
`timescale 1ns / 1ps
module dqow_dp
    import dqow_pkg::*;
#(
    parameter int WINDOW_SIZE  = WINDOW_SIZE_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    output t_status                        o_status,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_out_verdict,
    output logic                           o_out_window_full
);

    localparam int AW   = $clog2(WINDOW_SIZE);
    localparam int SW   = SAMPLE_WIDTH;
    localparam int PW   = SAMPLE_WIDTH + CRIT_W;
    localparam int CIDX = table_index(WINDOW_SIZE);
    localparam logic [AW-1:0] LAST = AW'(WINDOW_SIZE - 1);
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    logic [AW-1:0]          r_slot;
    logic                   r_filled;
    logic                   r_run;
    logic [AW-1:0]          r_rd_addr;
    logic                   r_rd_vld;
    logic                   r_rd_first;
    logic [1:0]             r_level;
    logic signed [SW-1:0]   r_min1;
    logic signed [SW-1:0]   r_min2;
    logic signed [SW-1:0]   r_max1;
    logic signed [SW-1:0]   r_max2;
    logic [SW-1:0]          r_range;
    logic [SW-1:0]          r_low_gap;
    logic [SW-1:0]          r_high_gap;
    logic [PW-1:0]          r_crit_rng;
    logic [PW-1:0]          r_low_sc;
    logic [PW-1:0]          r_high_sc;
    logic                   r_out_valid;
    t_verdict               r_verdict;
    logic                   r_out_full;

    logic [SW-1:0]          rd_data;
    logic signed [SW-1:0]   rd_sample;
    logic [SW:0]            range_full;
    logic [SW:0]            low_full;
    logic [SW:0]            high_full;
    logic [CRIT_W-1:0]      crit;
    t_verdict               verdict;

    dqow_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (r_slot),
        .i_wdata (i_sample),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_data)
    );

    assign rd_sample = $signed(rd_data);

    assign o_status.full_after = r_filled || (r_slot == LAST);
    assign o_status.rd_last    = (r_rd_addr == LAST);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign range_full = {r_max1[SW-1], r_max1} - {r_min1[SW-1], r_min1};
    assign low_full   = {r_min2[SW-1], r_min2} - {r_min1[SW-1], r_min1};
    assign high_full  = {r_max1[SW-1], r_max1} - {r_max2[SW-1], r_max2};
    assign crit       = crit_value(r_level, CIDX);

    always_comb begin
        if (!r_run) begin
            verdict = VERDICT_NONE;
        end else if (r_high_sc > r_crit_rng) begin
            verdict = VERDICT_HIGH;
        end else if (r_low_sc > r_crit_rng) begin
            verdict = VERDICT_LOW;
        end else begin
            verdict = VERDICT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_filled    <= 1'b0;
            r_run       <= 1'b0;
            r_rd_addr   <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_first  <= 1'b0;
            r_level     <= LEVEL_90;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_level <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_slot    <= (r_slot == LAST) ? '0 : r_slot + AW'(1);
                r_filled  <= o_status.full_after;
                r_run     <= o_status.full_after;
                r_rd_addr <= '0;
            end else if (i_cmd.rd_en) begin
                r_rd_addr <= r_rd_addr + AW'(1);
            end
            r_rd_vld   <= i_cmd.rd_en;
            r_rd_first <= i_cmd.rd_en && (r_rd_addr == '0);
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (r_rd_first) begin
                r_min1 <= rd_sample;
                r_max1 <= rd_sample;
                r_min2 <= S_MAX;
                r_max2 <= S_MIN;
            end else begin
                if (rd_sample < r_min1) begin
                    r_min2 <= r_min1;
                    r_min1 <= rd_sample;
                end else if (rd_sample < r_min2) begin
                    r_min2 <= rd_sample;
                end
                if (rd_sample > r_max1) begin
                    r_max2 <= r_max1;
                    r_max1 <= rd_sample;
                end else if (rd_sample > r_max2) begin
                    r_max2 <= rd_sample;
                end
            end
        end
        if (i_cmd.gaps_en) begin
            r_range    <= range_full[SW-1:0];
            r_low_gap  <= low_full[SW-1:0];
            r_high_gap <= high_full[SW-1:0];
        end
        if (i_cmd.mult_en) begin
            r_crit_rng <= {{SW{1'b0}}, crit} * {{CRIT_W{1'b0}}, r_range};
            r_low_sc   <= {r_low_gap, {CRIT_W{1'b0}}};
            r_high_sc  <= {r_high_gap, {CRIT_W{1'b0}}};
        end
        if (i_cmd.load_out) begin
            r_verdict  <= verdict;
            r_out_full <= r_run;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_verdict     = r_verdict;
    assign o_out_window_full = r_out_full;

endmodule

FILE: rtl/dixon_q_outlier_window_unit.sv
// While the window fills, the controller goes from ST_IDLE to ST_DONE; once it is full,
// it passes ST_SCAN, ST_DRAIN, ST_GAPS and ST_MULT first, and the result is registered
// in ST_DONE once the output is free. A sample is accepted only in ST_IDLE, so none is
// taken until the result is loaded; the scan reads one entry per cycle via the read port.
// Reset is synchronous and active low; it empties the window and selects the 90% level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dixon_q_outlier_window_unit
    import dqow_pkg::*;
#(
    parameter int WINDOW_SIZE  = WINDOW_SIZE_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_out_verdict,
    output logic                           o_out_window_full,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    dqow_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    dqow_dp #(
        .WINDOW_SIZE  (WINDOW_SIZE),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_sample          (i_in_sample),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_verdict     (o_out_verdict),
        .o_out_window_full (o_out_window_full)
    );

    `DQ_ASSERT(a_busy_after_transfer, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall)
    `DQ_ASSERT(a_no_verdict_when_filling, i_clk, i_rst_n, o_out_valid && !o_out_window_full |-> o_out_verdict == VERDICT_NONE)
    `DQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)

endmodule
